@@ hdl/hse_pkg.sv @@
// Shared types and constants of the symbol encoder: table entry layout,
// packer hand-off word and item kinds. No dependencies.
package hse_pkg;

  localparam int SYMBOL_BITS  = 8;
  localparam int MAX_CODE_LEN = 32;

  localparam int SYM_W   = 8;
  localparam int IDX_W   = 8;
  localparam int DEPTH   = 256;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int CFG_W   = 4;
  localparam int BYTE_W  = 8;
  // up to seven waiting bits plus the longest code
  localparam int ACC_W   = CODE_W + BYTE_W - 1;
  localparam int CNT_W   = 6;

  localparam logic [CFG_W-1:0] WIDTH_LIMIT =
    CFG_W'((SYMBOL_BITS < 8) ? SYMBOL_BITS : 8);
  localparam logic [LEN_W-1:0] LEN_LIMIT =
    LEN_W'((MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32);
  localparam logic [CFG_W-1:0] SYM_BITS_RESET = 4'd8;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic              is_flush;
    logic              unmatched;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
  } append_t;

endpackage

@@ hdl/hse_code_ram.sv @@
// Code table storage: one write port, one read port, registered read data.
// Depends on hse_pkg for the entry layout and depth.
module hse_code_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [hse_pkg::IDX_W-1:0] waddr,
  input  hse_pkg::entry_t         wdata,
  input  logic                    re,
  input  logic [hse_pkg::IDX_W-1:0] raddr,
  output hse_pkg::entry_t         rdata
);

  hse_pkg::entry_t mem [hse_pkg::DEPTH];
  hse_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/hse_packer.sv @@
// MSB-first bit packer: absorbs code words, hands out one byte a cycle
// while out_ready allows, via an output register. Depends on hse_pkg.
module hse_packer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       app_valid,
  input  hse_pkg::append_t           app,
  output logic                       app_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hse_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last,
  output logic                       out_unmatched
);

  logic [hse_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [hse_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       flag_r, flag_nxt;
  logic                       ob_valid_r, ob_valid_nxt;
  logic [hse_pkg::BYTE_W-1:0] ob_byte_r, ob_byte_nxt;
  logic                       ob_last_r, ob_last_nxt;
  logic                       ob_unm_r, ob_unm_nxt;

  logic                       out_free;
  logic                       emit;
  logic [hse_pkg::CNT_W-1:0]  shift;
  logic [hse_pkg::ACC_W-1:0]  shifted;
  logic [hse_pkg::CNT_W-1:0]  rem_cnt;
  logic [2:0]                 rem3;
  logic [7:0]                 keep_mask;
  logic [6:0]                 keep;
  logic [hse_pkg::LEN_W-1:0]  add_len;
  logic [hse_pkg::CODE_W-1:0] add_bits;

  assign out_free = !ob_valid_r || out_ready;
  assign emit     = (cnt_r >= 6'd8) && out_free;
  assign shift    = cnt_r - 6'd8;
  assign shifted  = acc_r >> shift;
  assign rem_cnt  = emit ? shift : cnt_r;
  assign app_ready = (rem_cnt < 6'd8);
  assign rem3     = rem_cnt[2:0];
  assign keep_mask = (8'd1 << rem3) - 8'd1;
  assign keep     = acc_r[6:0] & keep_mask[6:0];

  // a flush pads the waiting bits with zeros up to a whole byte
  always_comb begin
    if (app.is_flush) begin
      add_len  = (rem3 != 3'd0) ? (6'd8 - {3'b000, rem3}) : 6'd0;
      add_bits = '0;
      flag_nxt = 1'b0;
    end else begin
      add_len  = app.len;
      add_bits = app.bits;
      flag_nxt = app.unmatched;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = rem_cnt;
    if (app_valid && app_ready) begin
      acc_nxt = (hse_pkg::ACC_W'(keep) << add_len) | hse_pkg::ACC_W'(add_bits);
      cnt_nxt = {3'b000, rem3} + add_len;
    end
  end

  always_comb begin
    ob_valid_nxt = ob_valid_r;
    ob_byte_nxt  = ob_byte_r;
    ob_last_nxt  = ob_last_r;
    ob_unm_nxt   = ob_unm_r;
    if (emit) begin
      ob_valid_nxt = 1'b1;
      ob_byte_nxt  = shifted[7:0];
      ob_last_nxt  = (cnt_r < 6'd16);
      ob_unm_nxt   = flag_r;
    end else if (out_ready) begin
      ob_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ob_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      ob_valid_r <= ob_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    ob_byte_r <= ob_byte_nxt;
    ob_last_r <= ob_last_nxt;
    ob_unm_r  <= ob_unm_nxt;
    if (app_valid && app_ready) begin
      flag_r <= flag_nxt;
    end
  end

  assign out_valid     = ob_valid_r;
  assign out_byte      = ob_byte_r;
  assign out_last      = ob_last_r;
  assign out_unmatched = ob_unm_r;

endmodule

@@ hdl/huffman_symbol_encoder_unit.sv @@
// Top level of the static code-table symbol encoder.
// Depends on hse_pkg, hse_code_ram and hse_packer.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word a cycle while
//   in_ready is high: a load word writes a table entry, an encode word
//   looks up in_symbol (low cfg_symbol_bits bits) and appends its code, or
//   the raw symbol bits flagged unmatched on a miss; a flush word pads out
//   the partial byte. Output channel (out_valid/out_ready) gives one packed
//   byte a cycle while out_ready is high, first bit in the MSB.
//   cfg_we writes cfg_symbol_bits; write it only while the block is idle.
//   out_last marks a byte that leaves under eight bits in the packer.
//   Path: a word is registered in the table read stage, then absorbed
//   into the packer, whose bytes leave through the output register.
//   Throughput: one word a cycle while each word yields at most one byte
//   and out_ready is high; a word giving more bytes holds the packer, as
//   the output register moves one byte a cycle. Loads skip the read stage.
//   Reset: the table is marked empty at once by per-entry valid flops, the
//   pending bits are dropped and symbol width returns to 8; no clear pass.
//   Receiver stall: the byte is held in the output register; the packer
//   and then the input side back up and in_ready drops.
module huffman_symbol_encoder_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [hse_pkg::SYM_W-1:0]   in_symbol,
  input  logic [hse_pkg::CODE_W-1:0]  in_code_value,
  input  logic [hse_pkg::LEN_W-1:0]   in_code_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hse_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last,
  output logic                        out_unmatched,
  input  logic                        cfg_we,
  input  logic [hse_pkg::CFG_W-1:0]   cfg_symbol_bits
);

  logic [hse_pkg::CFG_W-1:0]  sym_bits_r;
  logic [hse_pkg::DEPTH-1:0]  vbits_r;

  // read stage
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_flush_r;
  logic                       s1_hit_r;
  logic [hse_pkg::CFG_W-1:0]  s1_width_r;
  logic [hse_pkg::SYM_W-1:0]  s1_raw_r;

  logic                       accept;
  hse_pkg::kind_t             kind;
  logic                       do_load, do_encode, do_flush;
  logic [hse_pkg::CFG_W-1:0]  eff_w;
  logic [8:0]                 sym_mask;
  logic [hse_pkg::SYM_W-1:0]  sym_idx;
  logic [hse_pkg::LEN_W-1:0]  len_sat;
  logic [32:0]                code_mask;
  hse_pkg::entry_t            wr_entry;
  hse_pkg::entry_t            rd_entry;

  hse_pkg::append_t           app;
  logic                       app_ready;

  assign accept = in_valid && in_ready;
  assign kind   = hse_pkg::kind_t'(in_kind);

  always_comb begin
    do_load   = 1'b0;
    do_encode = 1'b0;
    do_flush  = 1'b0;
    unique case (kind)
      hse_pkg::KIND_LOAD:   do_load   = accept;
      hse_pkg::KIND_ENCODE: do_encode = accept;
      hse_pkg::KIND_FLUSH:  do_flush  = accept;
      default:              ;
    endcase
  end

  always_comb begin
    if (sym_bits_r == '0) begin
      eff_w = 4'd1;
    end else if (sym_bits_r > hse_pkg::WIDTH_LIMIT) begin
      eff_w = hse_pkg::WIDTH_LIMIT;
    end else begin
      eff_w = sym_bits_r;
    end
  end

  assign sym_mask = (9'd1 << eff_w) - 9'd1;
  assign sym_idx  = in_symbol & sym_mask[7:0];

  assign len_sat  = (in_code_length > hse_pkg::LEN_LIMIT) ? hse_pkg::LEN_LIMIT
                                                          : in_code_length;
  assign code_mask     = (33'd1 << len_sat) - 33'd1;
  assign wr_entry.len  = len_sat;
  assign wr_entry.code = in_code_value & code_mask[31:0];

  hse_code_ram u_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (in_symbol),
    .wdata (wr_entry),
    .re    (do_encode),
    .raddr (sym_idx),
    .rdata (rd_entry)
  );

  // the read stage hands its word to the packer, or waits there
  assign in_ready = !s1_valid_r || app_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !app_ready;
    if (do_encode || do_flush) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    app.is_flush = s1_flush_r;
    if (s1_hit_r) begin
      app.unmatched = 1'b0;
      app.len       = rd_entry.len;
      app.bits      = rd_entry.code;
    end else begin
      app.unmatched = 1'b1;
      app.len       = hse_pkg::LEN_W'(s1_width_r);
      app.bits      = hse_pkg::CODE_W'(s1_raw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_bits_r <= hse_pkg::SYM_BITS_RESET;
      vbits_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sym_bits_r <= cfg_symbol_bits;
      end
      if (do_load) begin
        vbits_r[in_symbol] <= 1'b1;
      end
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_encode || do_flush) begin
      s1_flush_r <= do_flush;
      s1_hit_r   <= vbits_r[sym_idx];
      s1_width_r <= eff_w;
      s1_raw_r   <= sym_idx;
    end
  end

  hse_packer u_packer (
    .clk           (clk),
    .rst_n         (rst_n),
    .app_valid     (s1_valid_r),
    .app           (app),
    .app_ready     (app_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_unmatched (out_unmatched)
  );

endmodule

@@ hdl/hse_checker.sv @@
// Port-level checks for the symbol encoder, bound to the top level.
// Depends on huffman_symbol_encoder_unit port names only.
module hse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_unmatched
);

  // a stalled byte keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_last) && $stable(out_unmatched))
    else $error("output word changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset empties the read stage, so the input is open
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind huffman_symbol_encoder_unit hse_checker u_hse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_last      (out_last),
  .out_unmatched (out_unmatched)
);
